// File: rtl/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types, constants and helpers for the key debouncer with long-press
// detection.
// ----------------------------------------------------------------------------
`default_nettype none

package kdlp_pkg;

    localparam int KEY_COUNT   = 5;
    localparam int IDX_W       = 3;
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 1'b1;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd100;
    localparam logic [TICK_W-1:0] LONG_RESET     = 16'd500;

    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_CONFIRM = 2'd1;
    localparam logic [1:0] PHASE_DECIDE  = 2'd2;

    localparam logic [IDX_W-1:0] KEY_LEFT   = 3'd0;
    localparam logic [IDX_W-1:0] KEY_RIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] KEY_SELECT = 3'd2;
    localparam logic [IDX_W-1:0] KEY_DOWN   = 3'd3;
    localparam logic [IDX_W-1:0] KEY_UP     = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] key_index;
        logic             long_press;
    } result_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } pick_t;

    // Pressed is a low level; an index past the last key reads as released.
    function automatic logic key_is_down(input logic [KEY_COUNT-1:0] levels,
                                         input logic [IDX_W-1:0] idx);
        logic down;
        case (idx)
            KEY_LEFT:   down = ~levels[0];
            KEY_RIGHT:  down = ~levels[1];
            KEY_SELECT: down = ~levels[2];
            KEY_DOWN:   down = ~levels[3];
            KEY_UP:     down = ~levels[4];
            default:    down = 1'b0;
        endcase
        return down;
    endfunction

    // Lowest index wins: left, right, select, down, up.
    function automatic pick_t pick_key(input logic [KEY_COUNT-1:0] levels);
        pick_t p;
        p.found = 1'b1;
        if (!levels[0])
            p.idx = KEY_LEFT;
        else if (!levels[1])
            p.idx = KEY_RIGHT;
        else if (!levels[2])
            p.idx = KEY_SELECT;
        else if (!levels[3])
            p.idx = KEY_DOWN;
        else if (!levels[4])
            p.idx = KEY_UP;
        else
        begin
            p.found = 1'b0;
            p.idx   = KEY_LEFT;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/kdlp_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdlp_cfg_regs
// Debounce and long-press wait registers behind a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_cfg_regs
    import kdlp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data,
    output logic      [TICK_W-1:0]    debounce_ticks,
    output logic      [TICK_W-1:0]    long_ticks
);

    logic [TICK_W-1:0] debounce_reg;
    logic [TICK_W-1:0] debounce_next;
    logic [TICK_W-1:0] long_reg;
    logic [TICK_W-1:0] long_next;

    always_comb
    begin
        debounce_next = debounce_reg;
        long_next     = long_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_next = cfg_data;
                CFG_LONG:     long_next     = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            long_reg     <= LONG_RESET;
        end
        else
        begin
            debounce_reg <= debounce_next;
            long_reg     <= long_next;
        end
    end

    assign debounce_ticks = debounce_reg;
    assign long_ticks     = long_reg;

endmodule

`default_nettype wire

// File: rtl/kdlp_tracker.sv
// ----------------------------------------------------------------------------
// kdlp_tracker
// Phase, followed key and wait counter; one sample beat per step.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_tracker
    import kdlp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 beat,
    input  wire logic [KEY_COUNT-1:0] key_levels,
    input  wire logic [TICK_W-1:0]    debounce_ticks,
    input  wire logic [TICK_W-1:0]    long_ticks,
    output result_t                   res
);

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [IDX_W-1:0]  held_key_reg;
    logic [IDX_W-1:0]  held_key_next;
    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic              wait_done;
    logic              held_down;
    pick_t             pick;

    assign wait_done = (tick_count_reg <= TICK_W'(1));
    assign held_down = key_is_down(key_levels, held_key_reg);
    assign pick      = pick_key(key_levels);

    always_comb
    begin
        phase_next      = phase_reg;
        held_key_next   = held_key_reg;
        tick_count_next = tick_count_reg;
        res.valid       = 1'b0;
        res.key_index   = held_key_reg;
        res.long_press  = held_down;
        case (phase_reg)
            PHASE_CONFIRM:
            begin
                if (!wait_done)
                    tick_count_next = tick_count_reg - TICK_W'(1);
                else if (held_down)
                begin
                    phase_next      = PHASE_DECIDE;
                    tick_count_next = long_ticks;
                end
                else
                begin
                    phase_next      = PHASE_IDLE;
                    tick_count_next = '0;
                end
            end
            PHASE_DECIDE:
            begin
                if (!wait_done)
                    tick_count_next = tick_count_reg - TICK_W'(1);
                else
                begin
                    res.valid       = 1'b1;
                    phase_next      = PHASE_IDLE;
                    tick_count_next = '0;
                end
            end
            default:
            begin
                phase_next = PHASE_IDLE;
                if (pick.found)
                begin
                    held_key_next   = pick.idx;
                    phase_next      = PHASE_CONFIRM;
                    tick_count_next = debounce_ticks;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_IDLE;
            held_key_reg   <= '0;
            tick_count_reg <= '0;
        end
        else if (beat)
        begin
            phase_reg      <= phase_next;
            held_key_reg   <= held_key_next;
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/kdlp_out_reg.sv
// ----------------------------------------------------------------------------
// kdlp_out_reg
// Result register on the event channel; holds a beat while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_out_reg
    import kdlp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire result_t          res,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic      [IDX_W-1:0] key_index,
    output logic                  long_press,
    output logic                  busy
);

    logic             valid_reg;
    logic [IDX_W-1:0] key_index_reg;
    logic             long_press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= res.valid;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            key_index_reg  <= res.key_index;
            long_press_reg <= res.long_press;
        end
    end

    assign out_valid  = valid_reg;
    assign key_index  = key_index_reg;
    assign long_press = long_press_reg;
    assign busy       = valid_reg && out_stall;

endmodule

`default_nettype wire

// File: rtl/key_debounce_long_press.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press
// Five-key debouncer with short/long press events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, key_levels): one beat per timer tick,
//   five active-low key levels. Output channel (out_valid/out_stall,
//   key_index, long_press): one event beat per detected press.
//   cfg_we/cfg_index/cfg_data set debounce_ticks (0) and long_ticks (1);
//   write only while no press is being tracked.
// Throughput: one sample beat per cycle. in_stall rises only while an event
//   beat sits in the result register and the receiver stalls it.
// Event timing: the event appears on the output in the cycle after the sample beat
//   at which the long/short decision is made (detection tick plus
//   debounce_ticks plus long_ticks beats), held in the single result register.
// Reset: phase returns to idle, registers to 100 and 500, output empty.
// Receiver stall: the event beat holds; further samples wait until it is
//   taken.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_long_press
    import kdlp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [KEY_COUNT-1:0] key_levels,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [IDX_W-1:0]     key_index,
    output logic                      long_press
);

    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic              beat;
    logic              busy;
    result_t           res;

    assign in_stall = busy;
    assign beat     = in_valid && !busy;

    kdlp_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .debounce_ticks (debounce_ticks),
        .long_ticks     (long_ticks)
    );

    kdlp_tracker u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .beat           (beat),
        .key_levels     (key_levels),
        .debounce_ticks (debounce_ticks),
        .long_ticks     (long_ticks),
        .res            (res)
    );

    kdlp_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (beat),
        .res        (res),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .key_index  (key_index),
        .long_press (long_press),
        .busy       (busy)
    );

endmodule

`default_nettype wire

// File: rtl/kdlp_checker.sv
// ----------------------------------------------------------------------------
// kdlp_checker
// Port-level checks for the key debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_checker
    import kdlp_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [IDX_W-1:0]     key_index,
    input wire logic                 long_press
);

    // Hold a stalled event beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(key_index) && $stable(long_press))
        else $error("stalled event beat changed");

    // A blocked event must back-pressure the samples.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("sample accepted while event blocked");

    // An event comes only from an accepted sample beat.
    a_event_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("event without sample beat");

    // Events are never back to back: a taken event beat drops out_valid.
    a_event_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("back-to-back events");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_index <= KEY_UP)
        else $error("key index out of range");

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_index  (key_index),
    .long_press (long_press)
);

`default_nettype wire
